// ===== rtl/core/mac_pkg.sv =====
package mac_pkg;

  localparam int RING_DEPTH_DEF = 1024;

  localparam int STAMP_W = 48;
  localparam int PRICE_W = 32;
  localparam int PAIR_W  = PRICE_W + 1;
  localparam int WIN_W   = 32;

  localparam logic [WIN_W-1:0] SHORT_WINDOW_RST = WIN_W'(300000);
  localparam logic [WIN_W-1:0] LONG_WINDOW_RST  = WIN_W'(1200000);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_WINDOW  = 1'b1;

  // trend codes
  localparam logic signed [1:0] SIGN_NEG  = -2'sd1;
  localparam logic signed [1:0] SIGN_ZERO = 2'sd0;
  localparam logic signed [1:0] SIGN_POS  = 2'sd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OVF,
    S_SRD,
    S_SCHK,
    S_LCHK,
    S_MUL,
    S_CMP,
    S_EMIT
  } state_t;

endpackage

// ===== rtl/core/mac_in_if.sv =====
interface mac_in_if;
  logic                         valid;
  logic                         ready;
  logic [mac_pkg::STAMP_W-1:0]  stamp;
  logic                         is_bid;
  logic [mac_pkg::PRICE_W-1:0]  price;

  modport source (output valid, stamp, is_bid, price, input ready);
  modport sink   (input valid, stamp, is_bid, price, output ready);
endinterface

// ===== rtl/core/mac_out_if.sv =====
interface mac_out_if;
  logic                         valid;
  logic                         ready;
  logic                         go_long;
  logic                         sell_cross;
  logic [mac_pkg::PRICE_W-1:0]  best_bid;
  logic [mac_pkg::PRICE_W-1:0]  best_ask;
  logic signed [1:0]            trend_sign;
  logic                         evaluated;
  logic                         overflowed;

  modport source (output valid, go_long, sell_cross, best_bid, best_ask, trend_sign,
                  evaluated, overflowed, input ready);
  modport sink   (input valid, go_long, sell_cross, best_bid, best_ask, trend_sign,
                  evaluated, overflowed, output ready);
endinterface

// ===== rtl/core/mac_cmp.sv =====
module mac_cmp #(
  parameter int RING_DEPTH = mac_pkg::RING_DEPTH_DEF
) (
  input  logic                                               clk,
  input  logic                                               start,
  input  logic [mac_pkg::PAIR_W+$clog2(RING_DEPTH)-1:0]      short_sum,
  input  logic [mac_pkg::PAIR_W+$clog2(RING_DEPTH)-1:0]      long_sum,
  input  logic [$clog2(RING_DEPTH+1)-1:0]                    short_count,
  input  logic [$clog2(RING_DEPTH+1)-1:0]                    long_count,
  output logic signed [1:0]                                  sign
);

  localparam int CW     = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = mac_pkg::PAIR_W + $clog2(RING_DEPTH);
  localparam int PROD_W = SUM_W + CW;

  logic [PROD_W-1:0] prod_s;
  logic [PROD_W-1:0] prod_l;

  // cross products: short_avg ? long_avg  <=>  short_sum*long_count ? long_sum*short_count
  always_ff @(posedge clk) begin
    if (start) begin
      prod_s <= PROD_W'(short_sum) * PROD_W'(long_count);
      prod_l <= PROD_W'(long_sum) * PROD_W'(short_count);
    end
  end

  always_comb begin
    if (prod_s > prod_l) begin
      sign = mac_pkg::SIGN_POS;
    end else if (prod_s < prod_l) begin
      sign = mac_pkg::SIGN_NEG;
    end else begin
      sign = mac_pkg::SIGN_ZERO;
    end
  end

endmodule

// ===== rtl/core/moving_average_crossover_top.sv =====
// Channel  Dir  Handshake      Payload
// -------  ---  -------------  ------------------------------------------------
// cfg      in   cfg_we         cfg_index, cfg_data (short/long window)
// in       in   valid/ready    stamp, is_bid, price
// out      out  valid/ready    go_long, sell_cross, best_bid, best_ask,
//                              trend_sign, evaluated, overflowed
//
// First update of a stamp: the sequencer goes straight from IDLE to EMIT, which loads
// the result register, and takes the next transfer back in IDLE.
// Completing update: OVF, SRD, SCHK, LCHK, MUL, CMP, then EMIT loads the result;
// SCHK and LCHK repeat once for each entry aged out of the short and long windows;
// each eviction is one read of the single ring read port.
// in.ready is high only while the sequencer is idle; one update at a time.
// A finished result waits in the output register while the next update transfers;
// a result still held there by the receiver stalls the sequencer in EMIT.
// rst is synchronous; no clearing pass, ring entries are only read under counts.
module moving_average_crossover_top #(
  parameter int RING_DEPTH = mac_pkg::RING_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mac_pkg::WIN_W-1:0]        cfg_data,
  mac_in_if.sink                           in,
  mac_out_if.source                        out
);

  localparam int AW     = $clog2(RING_DEPTH);
  localparam int CW     = $clog2(RING_DEPTH + 1);
  localparam int PAIR_W = mac_pkg::PAIR_W;
  localparam int SUM_W  = PAIR_W + AW;
  localparam int ST_W   = mac_pkg::STAMP_W;
  localparam int ENT_W  = ST_W + PAIR_W;

  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(RING_DEPTH);

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    return (i == LAST_SLOT) ? '0 : i + 1'b1;
  endfunction

  // entry is older than the window relative to the newest stamp
  function automatic logic too_old(input logic [ST_W-1:0] newest,
                                   input logic [ST_W-1:0] old,
                                   input logic [mac_pkg::WIN_W-1:0] win);
    logic [ST_W-1:0] diff;
    diff = newest - old;
    return (newest > old) && (diff > ST_W'(win));
  endfunction

  // ring: {stamp, pair sum}, one write and one registered read per cycle
  logic [ENT_W-1:0] ring [RING_DEPTH];
  logic [ENT_W-1:0] rd_data;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;

  mac_pkg::state_t state, state_next;

  // configuration
  logic [mac_pkg::WIN_W-1:0] short_window;
  logic [mac_pkg::WIN_W-1:0] long_window;

  // running state
  logic [AW-1:0]            head_index, short_tail, long_tail;
  logic [CW-1:0]            short_count, long_count;
  logic [SUM_W-1:0]         short_sum, long_sum;
  logic signed [1:0]        last_sign;
  logic                     long_flag, short_flag;
  logic [mac_pkg::PRICE_W-1:0] bid_now, ask_now;
  logic [ST_W-1:0]          pending_stamp;
  logic [mac_pkg::PRICE_W-1:0] pending_bid, pending_ask;
  logic                     pending_valid;
  logic                     evaluated, overflowed;

  // update in flight
  logic [ST_W-1:0]          cur_stamp;
  logic [PAIR_W-1:0]        cur_pair;

  logic in_xfer, out_free, first_upd;
  logic short_evict, long_evict;
  logic ring_full, short_full;
  logic cmp_start;
  logic signed [1:0] cmp_sign;
  logic [ST_W-1:0]   rd_stamp;
  logic [PAIR_W-1:0] rd_pair;
  logic [mac_pkg::PRICE_W-1:0] pb_new, pa_new;

  assign rd_stamp = rd_data[ENT_W-1:PAIR_W];
  assign rd_pair  = rd_data[PAIR_W-1:0];

  assign in_xfer   = in.valid && in.ready;
  assign out_free  = !out.valid || out.ready;
  assign first_upd = !pending_valid || (in.stamp != pending_stamp);

  assign pb_new = in.is_bid ? in.price : pending_bid;
  assign pa_new = in.is_bid ? pending_ask : in.price;

  assign ring_full  = (long_count >= FULL_CNT);
  assign short_full = (short_count >= FULL_CNT);

  assign short_evict = (short_count != '0) && too_old(cur_stamp, rd_stamp, short_window);
  assign long_evict  = (long_count != '0) && too_old(cur_stamp, rd_stamp, long_window);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mac_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_next = first_upd ? mac_pkg::S_EMIT : mac_pkg::S_OVF;
        end
      end
      mac_pkg::S_OVF:  state_next = mac_pkg::S_SRD;
      mac_pkg::S_SRD:  state_next = mac_pkg::S_SCHK;
      mac_pkg::S_SCHK: state_next = short_evict ? mac_pkg::S_SCHK : mac_pkg::S_LCHK;
      mac_pkg::S_LCHK: state_next = long_evict ? mac_pkg::S_LCHK : mac_pkg::S_MUL;
      mac_pkg::S_MUL:  state_next = mac_pkg::S_CMP;
      mac_pkg::S_CMP:  state_next = mac_pkg::S_EMIT;
      mac_pkg::S_EMIT: state_next = out_free ? mac_pkg::S_IDLE : mac_pkg::S_EMIT;
      default:         state_next = mac_pkg::S_IDLE;
    endcase
  end

  // control strobes and read address
  always_comb begin
    in.ready  = 1'b0;
    mem_we    = 1'b0;
    cmp_start = 1'b0;
    rd_addr   = long_tail;
    unique case (state)
      mac_pkg::S_IDLE: in.ready = 1'b1;  // read of long_tail primes the overflow check
      mac_pkg::S_OVF:  mem_we = 1'b1;
      mac_pkg::S_SRD:  rd_addr = short_tail;
      mac_pkg::S_SCHK: rd_addr = short_evict ? next_slot(short_tail) : long_tail;
      mac_pkg::S_LCHK: rd_addr = next_slot(long_tail);
      mac_pkg::S_MUL:  cmp_start = 1'b1;
      mac_pkg::S_CMP:  rd_addr = long_tail;
      mac_pkg::S_EMIT: rd_addr = long_tail;
      default:         rd_addr = long_tail;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mac_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[head_index] <= {cur_stamp, cur_pair};
    end
    rd_data <= ring[rd_addr];
  end

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      short_window <= mac_pkg::SHORT_WINDOW_RST;
      long_window  <= mac_pkg::LONG_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mac_pkg::CFG_SHORT_WINDOW: short_window <= cfg_data;
        mac_pkg::CFG_LONG_WINDOW:  long_window  <= cfg_data;
      endcase
    end
  end

  // pair tracking, ring pointers, sums and trend
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index    <= '0;
      short_tail    <= '0;
      long_tail     <= '0;
      short_count   <= '0;
      long_count    <= '0;
      short_sum     <= '0;
      long_sum      <= '0;
      last_sign     <= mac_pkg::SIGN_ZERO;
      long_flag     <= 1'b0;
      short_flag    <= 1'b0;
      bid_now       <= '0;
      ask_now       <= '0;
      pending_stamp <= '0;
      pending_bid   <= '0;
      pending_ask   <= '0;
      pending_valid <= 1'b0;
      evaluated     <= 1'b0;
      overflowed    <= 1'b0;
    end else begin
      case (state)
        mac_pkg::S_IDLE: begin
          if (in_xfer) begin
            evaluated  <= 1'b0;
            overflowed <= 1'b0;
            cur_stamp  <= in.stamp;
            if (in.is_bid) begin
              bid_now <= in.price;
            end else begin
              ask_now <= in.price;
            end
            if (first_upd) begin
              pending_valid <= 1'b1;
              pending_stamp <= in.stamp;
              pending_bid   <= in.is_bid ? in.price : '0;
              pending_ask   <= in.is_bid ? '0 : in.price;
            end else begin
              pending_bid <= pb_new;
              pending_ask <= pa_new;
              cur_pair    <= PAIR_W'(pb_new) + PAIR_W'(pa_new);
            end
          end
        end
        mac_pkg::S_OVF: begin
          // rd_data holds the oldest entry; it goes first when the ring is full
          overflowed <= ring_full;
          head_index <= next_slot(head_index);
          long_sum   <= long_sum - (ring_full ? SUM_W'(rd_pair) : '0) + SUM_W'(cur_pair);
          if (ring_full) begin
            long_tail <= next_slot(long_tail);
          end else begin
            long_count <= long_count + 1'b1;
          end
          short_sum <= short_sum - ((ring_full && short_full) ? SUM_W'(rd_pair) : '0)
                       + SUM_W'(cur_pair);
          if (ring_full && short_full) begin
            short_tail <= next_slot(short_tail);
          end else begin
            short_count <= short_count + 1'b1;
          end
        end
        mac_pkg::S_SCHK: begin
          if (short_evict) begin
            short_sum   <= short_sum - SUM_W'(rd_pair);
            short_tail  <= next_slot(short_tail);
            short_count <= short_count - 1'b1;
          end
        end
        mac_pkg::S_LCHK: begin
          if (long_evict) begin
            long_sum   <= long_sum - SUM_W'(rd_pair);
            long_tail  <= next_slot(long_tail);
            long_count <= long_count - 1'b1;
          end
        end
        mac_pkg::S_CMP: begin
          long_flag  <= (last_sign == mac_pkg::SIGN_NEG) && (cmp_sign == mac_pkg::SIGN_POS);
          short_flag <= (last_sign == mac_pkg::SIGN_POS) && (cmp_sign == mac_pkg::SIGN_NEG);
          last_sign  <= cmp_sign;
          evaluated  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (state == mac_pkg::S_EMIT && out_free) begin
      out.valid <= 1'b1;
    end else if (out.ready) begin
      out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mac_pkg::S_EMIT && out_free) begin
      out.go_long    <= long_flag;
      out.sell_cross <= short_flag;
      out.best_bid   <= bid_now;
      out.best_ask   <= ask_now;
      out.trend_sign <= last_sign;
      out.evaluated  <= evaluated;
      out.overflowed <= overflowed;
    end
  end

  mac_cmp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_cmp (
    .clk         (clk),
    .start       (cmp_start),
    .short_sum   (short_sum),
    .long_sum    (long_sum),
    .short_count (short_count),
    .long_count  (long_count),
    .sign        (cmp_sign)
  );

`ifndef SYNTHESIS
  function automatic logic occ_ok(input logic [AW-1:0] head, input logic [AW-1:0] tail,
                                  input logic [CW-1:0] cnt);
    logic [CW-1:0] occ;
    occ = (head >= tail) ? CW'(head - tail) : CW'(FULL_CNT - CW'(tail) + CW'(head));
    return (occ == cnt) || ((occ == '0) && (cnt == FULL_CNT));
  endfunction

  a_long_occ: assert property (@(posedge clk) disable iff (rst)
    occ_ok(head_index, long_tail, long_count))
    else $error("long window count disagrees with ring pointers");

  a_short_occ: assert property (@(posedge clk) disable iff (rst)
    occ_ok(head_index, short_tail, short_count))
    else $error("short window count disagrees with ring pointers");

  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    (long_count <= FULL_CNT) && (short_count <= FULL_CNT))
    else $error("window count beyond ring depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in.ready)
    else $error("update taken while another is in progress");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> !(out.go_long && out.sell_cross) && (out.evaluated || !out.overflowed))
    else $error("inconsistent result flags");
`endif

endmodule
